FILE: hw/rtl/bcmc_pkg.sv
// Shared types and constants for the bus command motor controller.
package bcmc_pkg;

    // Bus event codes carried in the op field
    localparam logic [2:0] OP_WR_START = 3'd0;
    localparam logic [2:0] OP_WR_BYTE  = 3'd1;
    localparam logic [2:0] OP_RD_START = 3'd2;
    localparam logic [2:0] OP_RD_NEXT  = 3'd3;
    localparam logic [2:0] OP_STOP     = 3'd4;
    localparam logic [2:0] OP_SAMPLE   = 3'd5;

    // Configuration register indexes
    localparam logic CFG_DUTY_SCALE    = 1'b0;
    localparam logic CFG_CURRENT_LIMIT = 1'b1;

    // Drive direction codes
    localparam logic [1:0] DIR_OFF = 2'd0;
    localparam logic [1:0] DIR_FWD = 2'd1;
    localparam logic [1:0] DIR_REV = 2'd2;

    // Command characters
    localparam logic [7:0] CH_LO_E = 8'h65;
    localparam logic [7:0] CH_LO_C = 8'h63;
    localparam logic [7:0] CH_LO_H = 8'h68;
    localparam logic [7:0] CH_LO_O = 8'h6F;
    localparam logic [7:0] CH_ONE  = 8'h31;
    localparam logic [7:0] CH_TWO  = 8'h32;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_LO_I = 8'h69;
    localparam logic [7:0] CH_UP_I = 8'h49;
    localparam logic [7:0] CH_LO_L = 8'h6C;
    localparam logic [7:0] CH_UP_L = 8'h4C;
    localparam logic [7:0] CH_LO_F = 8'h66;
    localparam logic [7:0] CH_UP_F = 8'h46;
    localparam logic [7:0] CH_LO_R = 8'h72;
    localparam logic [7:0] CH_UP_R = 8'h52;

    localparam logic [7:0] ERROR_FILL = 8'h4F;
    localparam logic [7:0] READ_PAST  = 8'hFF;
    localparam logic [9:0] DUTY_MAX   = 10'd1023;

    // Classified action handed from the front end to the executor
    typedef enum logic [3:0] {
        ACT_ACK        = 4'd0,
        ACT_NACK       = 4'd1,
        ACT_READ_FIRST = 4'd2,
        ACT_READ_NEXT  = 4'd3,
        ACT_SAMPLE     = 4'd4,
        ACT_ECHO       = 4'd5,
        ACT_MOTOR      = 4'd6,
        ACT_QUERY      = 4'd7,
        ACT_LED        = 4'd8,
        ACT_BAD        = 4'd9
    } t_act;

    typedef struct packed {
        t_act       act;
        logic       motor_sel;
        logic [7:0] arg1;
        logic [7:0] arg2;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       acknowledge;
        logic [1:0] motor_one_dir;
        logic [9:0] motor_one_duty;
        logic [1:0] motor_two_dir;
        logic [9:0] motor_two_duty;
        logic       led_two;
        logic       led_three;
        logic       sample_channel;
        logic       command_done;
    } t_result;

endpackage

FILE: hw/rtl/bus_command_motor_controller_top.sv
// Top level of the bus command motor controller: front end, queues and executor.
//
//  channel   direction  handshake            payload
//  input     in         push / full          i_item   (op, data)
//  result    out        pop / empty          o_result (read_data .. command_done)
//  config    in         i_cfg_we, no wait    i_cfg_index, i_cfg_data
//
// One word in per cycle sustained while pop keeps the queues from filling,
// one result per word. An accepted word is stored in the mid queue; the executor
// takes it and stores its result in the result queue to be popped. It takes a word
// when one is queued and the result queue is not full; a high pop gives no room.
// With pop held low, two results and two words queue up before full rises.
// Synchronous reset clears framing, reply, currents, drives, lights; presets config.
module bus_command_motor_controller_top #(
    parameter int REPLY_BYTES = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  bcmc_pkg::t_item     i_item,
    output logic                empty,
    input  logic                pop,
    output bcmc_pkg::t_result   o_result,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [7:0]          i_cfg_data
);

    localparam int CMD_W = $bits(bcmc_pkg::t_cmd);
    localparam int RES_W = $bits(bcmc_pkg::t_result);

    logic              w_accept;
    bcmc_pkg::t_cmd    w_front_cmd;
    logic [CMD_W-1:0]  w_mid_rdata;
    bcmc_pkg::t_cmd    w_back_cmd;
    logic              w_mid_empty;
    logic              w_take;
    logic              w_out_full;
    bcmc_pkg::t_result w_back_res;
    logic [RES_W-1:0]  w_out_rdata;

    assign w_accept   = push && !full;
    assign w_back_cmd = bcmc_pkg::t_cmd'(w_mid_rdata);
    assign o_result   = bcmc_pkg::t_result'(w_out_rdata);

    // Frame and classify incoming words
    bcmc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_item),
        .o_cmd    (w_front_cmd)
    );

    // Decouple front end from executor
    bcmc_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_wdata (w_front_cmd),
        .i_pop   (w_take),
        .o_rdata (w_mid_rdata),
        .o_full  (full),
        .o_empty (w_mid_empty)
    );

    // Execute actions
    bcmc_back #(
        .REPLY_BYTES (REPLY_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (!w_mid_empty),
        .i_cmd       (w_back_cmd),
        .i_room      (!w_out_full),
        .o_take      (w_take),
        .o_result    (w_back_res)
    );

    // Hold results until popped
    bcmc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_take),
        .i_wdata (w_back_res),
        .i_pop   (pop),
        .o_rdata (w_out_rdata),
        .o_full  (w_out_full),
        .o_empty (empty)
    );

endmodule

FILE: hw/rtl/bcmc_fifo.sv
// Small first-in first-out queue used between and after the pipeline parts.
module bcmc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
        end
        if (w_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Store the incoming word
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

FILE: hw/rtl/bcmc_front.sv
// Front end: frames written bytes into commands and classifies each bus event.
module bcmc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  bcmc_pkg::t_item    i_item,
    output bcmc_pkg::t_cmd     o_cmd
);

    logic [1:0] r_count, n_count;
    logic [1:0] r_len, n_len;
    logic [7:0] r_byte0, n_byte0;
    logic [7:0] r_byte1, n_byte1;

    function automatic logic is_long(input logic [7:0] c);
        return (c == bcmc_pkg::CH_ONE) || (c == bcmc_pkg::CH_TWO) ||
               (c == bcmc_pkg::CH_LO_L) || (c == bcmc_pkg::CH_UP_L);
    endfunction

    function automatic bcmc_pkg::t_act classify(input logic [7:0] c);
        bcmc_pkg::t_act a;
        if (c == bcmc_pkg::CH_LO_E) begin
            a = bcmc_pkg::ACT_ECHO;
        end else if (c == bcmc_pkg::CH_ONE || c == bcmc_pkg::CH_TWO) begin
            a = bcmc_pkg::ACT_MOTOR;
        end else if (c == bcmc_pkg::CH_LO_I || c == bcmc_pkg::CH_UP_I) begin
            a = bcmc_pkg::ACT_QUERY;
        end else if (c == bcmc_pkg::CH_LO_L || c == bcmc_pkg::CH_UP_L) begin
            a = bcmc_pkg::ACT_LED;
        end else begin
            a = bcmc_pkg::ACT_BAD;
        end
        return a;
    endfunction

    // Frame bytes and pick the action for this word
    always_comb begin
        n_count = r_count;
        n_len   = r_len;
        n_byte0 = r_byte0;
        n_byte1 = r_byte1;
        o_cmd.act       = bcmc_pkg::ACT_ACK;
        o_cmd.motor_sel = (r_byte0 == bcmc_pkg::CH_TWO);
        o_cmd.arg1      = r_byte1;
        o_cmd.arg2      = i_item.data;
        case (i_item.op)
            bcmc_pkg::OP_WR_START: begin
                n_count = 2'd0;
            end
            bcmc_pkg::OP_WR_BYTE: begin
                if (r_count == 2'd0) begin
                    n_byte0 = i_item.data;
                    n_count = 2'd1;
                    if (is_long(i_item.data)) begin
                        n_len = 2'd3;
                    end else begin
                        n_len     = 2'd1;
                        o_cmd.act = classify(i_item.data);
                    end
                end else if (r_count < r_len) begin
                    if (r_count == 2'd1) begin
                        n_byte1 = i_item.data;
                        n_count = 2'd2;
                    end else begin
                        // Third byte completes a long command
                        n_count   = 2'd3;
                        o_cmd.act = classify(r_byte0);
                    end
                end
            end
            bcmc_pkg::OP_RD_START: o_cmd.act = bcmc_pkg::ACT_READ_FIRST;
            bcmc_pkg::OP_RD_NEXT:  o_cmd.act = bcmc_pkg::ACT_READ_NEXT;
            bcmc_pkg::OP_SAMPLE:   o_cmd.act = bcmc_pkg::ACT_SAMPLE;
            default:               o_cmd.act = bcmc_pkg::ACT_NACK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_len   <= 2'd0;
        end else if (i_accept) begin
            r_count <= n_count;
            r_len   <= n_len;
        end
    end

    // Hold command bytes; no reset needed
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_byte0 <= n_byte0;
            r_byte1 <= n_byte1;
        end
    end

endmodule

FILE: hw/rtl/bcmc_back.sv
// Back end: executes classified actions, holds drive state and the reply buffer.
module bcmc_back #(
    parameter int REPLY_BYTES = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_valid,
    input  bcmc_pkg::t_cmd     i_cmd,
    input  logic               i_room,
    output logic               o_take,
    output bcmc_pkg::t_result  o_result
);

    localparam int AW = $clog2(REPLY_BYTES);
    localparam int IW = $clog2(REPLY_BYTES + 1);

    logic [2:0]    r_duty_scale;
    logic [7:0]    r_limit;
    logic [7:0]    r_reply [REPLY_BYTES];
    logic [7:0]    n_reply [REPLY_BYTES];
    logic [IW-1:0] r_idx, n_idx;
    logic [7:0]    r_cur1, n_cur1;
    logic [7:0]    r_cur2, n_cur2;
    logic          r_chan, n_chan;
    logic [1:0]    r_dir [2];
    logic [1:0]    n_dir [2];
    logic [9:0]    r_duty [2];
    logic [9:0]    n_duty [2];
    logic          r_light [2];
    logic          n_light [2];

    logic [AW-1:0] w_rd_addr;
    logic          w_in_range;
    logic [10:0]   w_prod;
    logic [9:0]    w_sat;
    logic          w_fill;
    logic          w_m;
    logic [7:0]    w_rd;
    logic          w_ack;
    logic          w_done;

    assign o_take = i_valid && i_room;

    // Register configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_scale <= 3'd4;
            r_limit      <= 8'd200;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bcmc_pkg::CFG_DUTY_SCALE:    r_duty_scale <= i_cfg_data[2:0];
                bcmc_pkg::CFG_CURRENT_LIMIT: r_limit      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Scale speed to duty and saturate
    assign w_prod = 11'(i_cmd.arg2) * 11'(r_duty_scale);
    assign w_sat  = (w_prod > 11'(bcmc_pkg::DUTY_MAX)) ? bcmc_pkg::DUTY_MAX : w_prod[9:0];
    assign w_m    = i_cmd.motor_sel;

    // Select the reply byte to read
    assign w_rd_addr  = (i_cmd.act == bcmc_pkg::ACT_READ_FIRST) ? '0 : r_idx[AW-1:0];
    assign w_in_range = (i_cmd.act == bcmc_pkg::ACT_READ_FIRST) ||
                        (r_idx < IW'(REPLY_BYTES));

    // Execute the action and form next state
    always_comb begin
        n_reply = r_reply;
        n_idx   = r_idx;
        n_cur1  = r_cur1;
        n_cur2  = r_cur2;
        n_chan  = r_chan;
        n_dir   = r_dir;
        n_duty  = r_duty;
        n_light = r_light;
        w_fill  = 1'b0;
        w_rd    = 8'd0;
        w_ack   = 1'b1;
        w_done  = 1'b0;
        case (i_cmd.act)
            bcmc_pkg::ACT_ACK: ;
            bcmc_pkg::ACT_NACK: w_ack = 1'b0;
            bcmc_pkg::ACT_READ_FIRST, bcmc_pkg::ACT_READ_NEXT: begin
                if (w_in_range) begin
                    w_rd  = r_reply[w_rd_addr];
                    n_idx = IW'(w_rd_addr) + IW'(1);
                end else begin
                    w_rd = bcmc_pkg::READ_PAST;
                end
            end
            bcmc_pkg::ACT_SAMPLE: begin
                if (!r_chan) begin
                    n_cur1 = i_cmd.arg2;
                end else begin
                    n_cur2 = i_cmd.arg2;
                end
                n_chan     = !r_chan;
                n_light[0] = (n_cur1 > r_limit);
                n_light[1] = (n_cur2 > r_limit);
                if (n_light[0]) begin
                    n_duty[0] = 10'd0;
                end
                if (n_light[1]) begin
                    n_duty[1] = 10'd0;
                end
            end
            bcmc_pkg::ACT_ECHO: begin
                w_done     = 1'b1;
                n_reply[0] = bcmc_pkg::CH_LO_E;
                n_reply[1] = bcmc_pkg::CH_LO_C;
                n_reply[2] = bcmc_pkg::CH_LO_H;
                n_reply[3] = bcmc_pkg::CH_LO_O;
            end
            bcmc_pkg::ACT_MOTOR: begin
                w_done = 1'b1;
                if (i_cmd.arg1 == bcmc_pkg::CH_LO_F || i_cmd.arg1 == bcmc_pkg::CH_UP_F) begin
                    n_dir[w_m]  = bcmc_pkg::DIR_FWD;
                    n_duty[w_m] = w_sat;
                end else if (i_cmd.arg1 == bcmc_pkg::CH_LO_R ||
                             i_cmd.arg1 == bcmc_pkg::CH_UP_R) begin
                    n_dir[w_m]  = bcmc_pkg::DIR_REV;
                    n_duty[w_m] = w_sat;
                end else begin
                    w_fill = 1'b1;
                end
            end
            bcmc_pkg::ACT_QUERY: begin
                w_done     = 1'b1;
                n_reply[0] = r_cur1;
                n_reply[1] = r_cur2;
            end
            bcmc_pkg::ACT_LED: begin
                w_done = 1'b1;
                if (i_cmd.arg1 == bcmc_pkg::CH_TWO) begin
                    if (i_cmd.arg2 == bcmc_pkg::CH_ONE || i_cmd.arg2 == 8'd1) begin
                        n_light[0] = 1'b1;
                    end else if (i_cmd.arg2 == bcmc_pkg::CH_ZERO || i_cmd.arg2 == 8'd0) begin
                        n_light[0] = 1'b0;
                    end else begin
                        w_fill = 1'b1;
                    end
                end else if (i_cmd.arg1 == bcmc_pkg::CH_THREE) begin
                    if (i_cmd.arg2 == bcmc_pkg::CH_ONE || i_cmd.arg2 == 8'd1) begin
                        n_light[1] = 1'b1;
                    end else if (i_cmd.arg2 == bcmc_pkg::CH_ZERO || i_cmd.arg2 == 8'd0) begin
                        n_light[1] = 1'b0;
                    end
                end
            end
            bcmc_pkg::ACT_BAD: begin
                w_done = 1'b1;
                w_fill = 1'b1;
            end
            default: ;
        endcase
        // Fill the whole reply on a bad command, motor direction or light-two value
        if (w_fill) begin
            for (int k = 0; k < REPLY_BYTES; k++) begin
                n_reply[k] = bcmc_pkg::ERROR_FILL;
            end
        end
    end

    // Update state when the word is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < REPLY_BYTES; k++) begin
                r_reply[k] <= 8'd0;
            end
            r_idx   <= '0;
            r_cur1  <= 8'd0;
            r_cur2  <= 8'd0;
            r_chan  <= 1'b0;
            r_dir   <= '{bcmc_pkg::DIR_OFF, bcmc_pkg::DIR_OFF};
            r_duty  <= '{10'd0, 10'd0};
            r_light <= '{1'b0, 1'b0};
        end else if (o_take) begin
            r_reply <= n_reply;
            r_idx   <= n_idx;
            r_cur1  <= n_cur1;
            r_cur2  <= n_cur2;
            r_chan  <= n_chan;
            r_dir   <= n_dir;
            r_duty  <= n_duty;
            r_light <= n_light;
        end
    end

    // Assemble the result word from state after the step
    always_comb begin
        o_result.read_data      = w_rd;
        o_result.acknowledge    = w_ack;
        o_result.motor_one_dir  = n_dir[0];
        o_result.motor_one_duty = n_duty[0];
        o_result.motor_two_dir  = n_dir[1];
        o_result.motor_two_duty = n_duty[1];
        o_result.led_two        = n_light[0];
        o_result.led_three      = n_light[1];
        o_result.sample_channel = n_chan;
        o_result.command_done   = w_done;
    end

endmodule
